// ===== hw/rtl/rde_pkg.sv =====
// rde_pkg: shared constants, register indexes and the control/status
// structs between the radix digit emitter controller and datapath.
// No dependencies.
package rde_pkg;

  localparam int MAX_RADIX_DEF  = 16;
  localparam int VALUE_BITS_DEF = 64;
  localparam int DIV_BITS       = 8;   // dividend bits consumed per division cycle
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int SYM_W          = 8;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_ADDR_W     = 5;

  localparam logic [1:0] REG_RADIX        = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic load;       // take a new word, clear count
    logic div_step;   // one long-division step
    logic div_last;   // final cycle of a digit: store remainder
    logic emit_rd;    // read digit store at idx
    logic emit_ld;    // load output register
  } rde_cmd_t;

  typedef struct packed {
    logic base_ok;
    logic quot_zero;
    logic count_full;
    logic idx_zero;
    logic out_free;
  } rde_stat_t;

endpackage

// ===== hw/rtl/rde_in_if.sv =====
// rde_in_if: valid/ready channel carrying one integer to convert.
// Depends on nothing.
interface rde_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        as_signed;

  modport source (output valid, output value, output as_signed, input ready);
  modport sink   (input valid, input value, input as_signed, output ready);
endinterface

// ===== hw/rtl/rde_out_if.sv =====
// rde_out_if: valid/ready channel carrying one symbol byte per word.
// Depends on nothing.
interface rde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== hw/rtl/rde_regs.sv =====
// rde_regs: APB-style configuration registers (radix, symbol table).
// Depends on rde_pkg.
module rde_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rde_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rde_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [rde_pkg::RADIX_W-1:0]      radix,
  output logic [63:0]                      symbols_low,
  output logic [63:0]                      symbols_high
);
  import rde_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [63:0]        sym_low_r;
  logic [63:0]        sym_high_r;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      sym_low_r  <= '0;
      sym_high_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIX:        radix_r    <= pwdata[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  sym_low_r  <= pwdata;
        REG_SYMBOLS_HIGH: sym_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIX:        prdata = {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_r};
      REG_SYMBOLS_LOW:  prdata = sym_low_r;
      REG_SYMBOLS_HIGH: prdata = sym_high_r;
      default:          prdata = '0;
    endcase
  end

  assign radix        = radix_r;
  assign symbols_low  = sym_low_r;
  assign symbols_high = sym_high_r;

endmodule

// ===== hw/rtl/rde_ctrl.sv =====
// rde_ctrl: sequencer for the radix digit emitter. Steps the long
// division a digit at a time, then reads the digits back for output.
// Depends on rde_pkg.
module rde_ctrl #(
  parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rde_pkg::rde_stat_t stat,
  output rde_pkg::rde_cmd_t  cmd
);
  import rde_pkg::*;

  localparam int STEPS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              step_end;
  logic              accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign step_end = (step_r == STEP_W'(STEPS - 1));

  always_comb begin
    cmd          = '0;
    cmd.load     = accept & stat.base_ok;
    cmd.div_step = (state_r == ST_DIV);
    cmd.div_last = (state_r == ST_DIV) & step_end;
    cmd.emit_rd  = (state_r == ST_EMIT_RD);
    cmd.emit_ld  = (state_r == ST_EMIT_LD) & stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (accept && stat.base_ok) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_end) begin
            step_r <= '0;
            if (stat.quot_zero || stat.count_full) begin
              state_r <= ST_EMIT_RD;
            end
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (stat.out_free) begin
            state_r <= stat.idx_zero ? ST_IDLE : ST_EMIT_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rde_dpath.sv =====
// rde_dpath: magnitude, 8-bit-per-cycle long division by the radix,
// digit store, symbol lookup and output register.
// Depends on rde_pkg and rde_out_if.
module rde_dpath #(
  parameter int MAX_RADIX  = rde_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rde_pkg::rde_cmd_t           cmd,
  output rde_pkg::rde_stat_t          stat,
  input  logic [rde_pkg::RADIX_W-1:0] radix,
  input  logic [63:0]                 symbols_low,
  input  logic [63:0]                 symbols_high,
  input  logic [63:0]                 in_value,
  input  logic                        in_as_signed,
  rde_out_if.source                   out_word
);
  import rde_pkg::*;

  localparam int STEPS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W  = STEPS * DIV_BITS;
  localparam int ADDR_W = $clog2(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);

  logic [PAD_W-1:0]    work_r, work_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [ADDR_W-1:0]   idx_r;
  logic [DIGIT_W-1:0]  rd_data_r;
  logic [DIGIT_W-1:0]  digit_mem [VALUE_BITS];
  logic                out_valid_r;
  logic [SYM_W-1:0]    out_symbol_r;
  logic                out_last_r;

  logic [RADIX_W-1:0]    base;
  logic [VALUE_BITS-1:0] v_in, v_mag;
  logic [DIV_BITS-1:0]   qbits;
  logic [127:0]          sym_tab;

  assign base = (radix > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix;
  assign v_in  = in_value[VALUE_BITS-1:0];
  assign v_mag = (in_as_signed && v_in[VALUE_BITS-1]) ? (~v_in + VALUE_BITS'(1)) : v_in;

  // restoring division, one dividend bit per inner step
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   t;
    r = rem_r;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, work_r[PAD_W-1-i]};
      if (t >= base) begin
        t = t - base;
        qbits[DIV_BITS-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_nxt  = r;
    work_nxt = (work_r << DIV_BITS) | PAD_W'(qbits);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rem_r   <= '0;
    end else if (cmd.load) begin
      work_r  <= PAD_W'(v_mag);
      rem_r   <= '0;
      count_r <= '0;
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
      if (cmd.div_last) begin
        rem_r   <= '0;
        count_r <= count_r + CNT_W'(1);
        idx_r   <= count_r[ADDR_W-1:0];
      end else begin
        rem_r <= rem_nxt;
      end
    end else if (cmd.emit_ld) begin
      idx_r <= idx_r - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_last) begin
      digit_mem[count_r[ADDR_W-1:0]] <= rem_nxt;
    end
    if (cmd.emit_rd) begin
      rd_data_r <= digit_mem[idx_r];
    end
  end

  assign sym_tab = {symbols_high, symbols_low};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r & ~out_word.ready) | cmd.emit_ld;
    end
    if (cmd.emit_ld) begin
      out_symbol_r <= sym_tab[{rd_data_r, 3'b000} +: SYM_W];
      out_last_r   <= (idx_r == '0);
    end
  end

  assign out_word.valid  = out_valid_r;
  assign out_word.symbol = out_symbol_r;
  assign out_word.last   = out_last_r;

  always_comb begin
    stat            = '0;
    stat.base_ok    = (radix >= RADIX_W'(2));
    stat.quot_zero  = (work_nxt == '0);
    stat.count_full = (count_r == CNT_W'(VALUE_BITS - 1));
    stat.idx_zero   = (idx_r == '0);
    stat.out_free   = ~out_valid_r | out_word.ready;
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> (!out_valid_r || out_word.ready))
    else $error("output register overwritten while held");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |-> (count_r < CNT_W'(VALUE_BITS)))
    else $error("digit count overflow");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (count_r == '0 && rem_r == '0))
    else $error("load did not clear digit state");
`endif

endmodule

// ===== hw/rtl/radix_digit_emitter.sv =====
// radix_digit_emitter: top level, integer to radix-string digit emitter.
// Depends on rde_pkg, rde_in_if, rde_out_if, rde_regs, rde_ctrl, rde_dpath.
//
//   channel   dir  handshake        payload
//   in_word   in   valid/ready      value[63:0], as_signed
//   out_word  out  valid/ready      symbol[7:0], last
//   apb       in   psel/penable     paddr[4:0], pwdata/prdata[63:0]
//
// Per word: the word is accepted, then each digit takes a full pass of the
// 8-bit-per-cycle long divider over the value; the digits are then emitted
// by a registered digit-store read followed by an output register load.
// A word with radix below 2 is taken and emits nothing.
// Synchronous active-low reset; in_word.ready is high only when idle.
// Output stalls hold the emit sequencer; no symbol is dropped.
module radix_digit_emitter #(
  parameter int MAX_RADIX  = rde_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rde_in_if.sink                         in_word,
  rde_out_if.source                      out_word,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rde_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rde_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rde_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic [63:0]        symbols_low;
  logic [63:0]        symbols_high;
  rde_cmd_t           cmd;
  rde_stat_t          stat;
  logic               in_ready;

  rde_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .radix        (radix),
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high)
  );

  rde_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_word.ready = in_ready;

  rde_dpath #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .radix        (radix),
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high),
    .in_value     (in_word.value),
    .in_as_signed (in_word.as_signed),
    .out_word     (out_word)
  );

endmodule

// ===== bench/rde_digit_check.sv =====
// rde_digit_check: watches the input, output and APB ports of radix_digit_emitter,
// predicts the symbol words of each accepted integer and compares them in order.
// Depends on rde_pkg, rde_in_if and rde_out_if.
`timescale 1ns / 100ps
module rde_digit_check (
  input  logic                           clk,
  input  logic                           rst_n,
  rde_in_if                              in_word,
  rde_out_if                             out_word,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [rde_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             glyphs_pending
);
  import rde_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } glyph_t;

  logic [RADIX_W-1:0] radix_q;
  logic [63:0]        sym_lo_q;
  logic [63:0]        sym_hi_q;
  glyph_t             glyphs_due[$];

  function automatic logic [SYM_W-1:0] symbol_for(logic [DIGIT_W-1:0] d);
    if (d[3]) return sym_hi_q[8 * d[2:0] +: SYM_W];
    return sym_lo_q[8 * d[2:0] +: SYM_W];
  endfunction

  // digits are split least significant first, queued most significant first
  function automatic void expand_digits(logic [63:0] value, logic sgn);
    logic [63:0]        mag;
    logic [63:0]        base;
    logic [DIGIT_W-1:0] digs [64];
    glyph_t             g;
    int                 n;
    mag  = value;
    base = 64'(radix_q);
    if (base < 2) return;
    if (base > MAX_RADIX_DEF) base = 64'(MAX_RADIX_DEF);
    if (sgn && mag[63]) mag = -mag;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0 && n < 64);
    for (int k = n - 1; k >= 0; k--) begin
      g.symbol = symbol_for(digs[k]);
      g.last   = (k == 0);
      glyphs_due.push_back(g);
    end
  endfunction

  always @(posedge clk) begin
    glyph_t     want;
    logic [1:0] reg_idx;
    if (!rst_n) begin
      radix_q    = '0;
      sym_lo_q   = '0;
      sym_hi_q   = '0;
      fail_count = 0;
      glyphs_due.delete();
    end else begin
      if (out_word.valid && out_word.ready) begin
        if (glyphs_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got symbol %02h last %0b",
                   $time, out_word.symbol, out_word.last);
          fail_count++;
        end else begin
          want = glyphs_due.pop_front();
          if (want.symbol !== out_word.symbol) begin
            $display("%0t: symbol mismatch, expected %02h, got %02h",
                     $time, want.symbol, out_word.symbol);
            fail_count++;
          end
          if (want.last !== out_word.last) begin
            $display("%0t: last mismatch, expected %0b, got %0b",
                     $time, want.last, out_word.last);
            fail_count++;
          end
        end
      end
      if (in_word.valid && in_word.ready)
        expand_digits(in_word.value, in_word.as_signed);
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr[CFG_ADDR_W-1:3];
        case (reg_idx)
          REG_RADIX:        radix_q  = pwdata[RADIX_W-1:0];
          REG_SYMBOLS_LOW:  sym_lo_q = pwdata;
          REG_SYMBOLS_HIGH: sym_hi_q = pwdata;
          default: ;
        endcase
      end
    end
    glyphs_pending = glyphs_due.size();
  end

endmodule

// ===== bench/tb.sv =====
// tb: drives radix_digit_emitter with directed and random integers under several
// radix and symbol settings, with random stalls on both channels; verdict from rde_digit_check.
// Depends on rde_pkg, rde_in_if, rde_out_if, radix_digit_emitter and rde_digit_check.
`timescale 1ns / 100ps
module tb;
  import rde_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 700;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 12;
  localparam logic [RADIX_W-1:0] RADIX_PLAN [10] =
    '{5'd10, 5'd2, 5'd16, 5'd31, 5'd3, 5'd0, 5'd7, 5'd17, 5'd1, 5'd0};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  int                    fail_count;
  int                    glyphs_pending;
  int                    cycles;
  int                    armed_words;
  bit                    steady;
  bit                    hold_armed;

  rde_in_if  in_word();
  rde_out_if out_word();

  radix_digit_emitter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rde_digit_check glyph_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_word        (in_word),
    .out_word       (out_word),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .glyphs_pending (glyphs_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** radix_digit_emitter: FAILED **");
    $finish;
  end

  // output side: random stalls per word, one long hold-off when armed
  initial begin
    int gap;
    out_word.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 7);
      if (hold_armed && armed_words >= HOLD_AFTER) begin
        hold_armed = 1'b0;
        gap        = LONG_HOLD;
      end
      if (gap != 0) begin
        out_word.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_word.ready <= 1'b1;
      do @(posedge clk); while (!out_word.valid);
      if (hold_armed) armed_words++;
    end
  end

  task automatic send_word(input logic [63:0] v, input logic s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid     <= 1'b1;
    in_word.value     <= v;
    in_word.as_signed <= s;
    do @(posedge clk); while (!in_word.ready);
  endtask

  task automatic end_burst();
    in_word.valid <= 1'b0;
  endtask

  task automatic await_drain();
    do @(posedge clk); while (glyphs_pending != 0);
  endtask

  // radix below 2 leaves nothing to wait on, so allow the worst latency too
  task automatic settle();
    await_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 3'b000});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [63:0] draw_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: v = v >> $urandom_range(0, 63);
      2:    v = -(v >> $urandom_range(0, 63));
      3: begin
        case ($urandom_range(0, 3))
          0: v = 64'd0;
          1: v = 64'h8000_0000_0000_0000;
          2: v = '1;
          default: v = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [RADIX_W-1:0] rad;
    int                 n;
    steady            = 1'b0;
    hold_armed        = 1'b0;
    armed_words       = 0;
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_word.valid     <= 1'b0;
    in_word.value     <= '0;
    in_word.as_signed <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // radix still at reset: words are taken, nothing comes out
    send_word(64'd42, 1'b0);
    send_word('1, 1'b1);
    end_burst();
    settle();
    write_reg(REG_SYMBOLS_LOW, "76543210");
    write_reg(REG_SYMBOLS_HIGH, "fedcba98");
    write_reg(REG_RADIX, CFG_DATA_W'(10));
    send_word(64'd0, 1'b0);
    send_word(64'd0, 1'b1);
    send_word('1, 1'b0);
    send_word('1, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(64'd1, 1'b1);
    send_word(64'd9, 1'b0);
    send_word(64'd10, 1'b1);
    end_burst();
    settle();
    write_reg(REG_RADIX, CFG_DATA_W'(2));
    send_word('1, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'd0, 1'b1);
    send_word(64'd5, 1'b0);
    end_burst();
    settle();
    write_reg(REG_RADIX, CFG_DATA_W'(16));
    send_word('1, 1'b0);
    send_word(64'h0123_4567_89AB_CDEF, 1'b0);
    send_word(64'hFEDC_BA98_7654_3210, 1'b1);
    end_burst();
    settle();
    // above the maximum radix: saturates
    write_reg(REG_RADIX, '1);
    send_word(64'hFEDC_BA98_7654_3210, 1'b0);
    send_word(64'hFF, 1'b0);
    end_burst();
    settle();
    write_reg(REG_RADIX, CFG_DATA_W'(1));
    send_word(64'd7, 1'b0);
    end_burst();

    for (int p = 0; p < 10; p++) begin
      settle();
      rad = (p == 9) ? RADIX_W'($urandom_range(2, 16)) : RADIX_PLAN[p];
      case (p)
        3: begin
          write_reg(REG_SYMBOLS_LOW, '1);
          write_reg(REG_SYMBOLS_HIGH, '1);
        end
        4: begin
          write_reg(REG_SYMBOLS_LOW, '0);
          write_reg(REG_SYMBOLS_HIGH, '0);
        end
        default: begin
          write_reg(REG_SYMBOLS_LOW, {$urandom, $urandom});
          write_reg(REG_SYMBOLS_HIGH, {$urandom, $urandom});
        end
      endcase
      write_reg(REG_RADIX, CFG_DATA_W'(rad));
      steady = (p == 2);
      if (p == 0) begin
        armed_words = 0;
        hold_armed  = 1'b1;
      end
      n = (rad < 2) ? 4 : 10;
      for (int i = 0; i < n; i++) begin
        send_word(draw_value(), 1'($urandom_range(0, 1)));
        if (p == 2 && i == 6) begin
          end_burst();
          await_drain();
        end
      end
      end_burst();
    end
    steady = 1'b0;

    await_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && glyphs_pending == 0)
      $display("** radix_digit_emitter: PASSED **");
    else
      $display("** radix_digit_emitter: FAILED **");
    $finish;
  end

endmodule
